>>> design/ttr_pkg.sv
// Shared types and constants of the scaled 5x7 text rectangle renderer.
`timescale 1ns / 1ps

package ttr_pkg;

    // Default largest font cell size
    localparam int MAX_SCALE_DEF = 8;

    // Glyph geometry
    localparam int FIRST_CODE = 8'h20;
    localparam int LAST_CODE  = 8'h7A;
    localparam int GLYPH_COLS = 5;
    localparam int GLYPH_ROWS = 7;
    localparam int ADVANCE    = 6;
    localparam int LINE_STEP  = 8;
    localparam int GLYPH_CNT  = LAST_CODE - FIRST_CODE + 1;
    localparam int GLYPH_AW   = $clog2(GLYPH_CNT);
    localparam int GLYPH_W    = 8 * GLYPH_COLS;

    // Position math is done one bit wider than the cursor, no wrap
    localparam int CUR_W = 16;
    localparam int POS_W = CUR_W + 1;
    localparam int DIM_W = 9;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_FG_COLOR = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BG_COLOR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCR_W    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCR_H    = 3'd4;

    // Input function codes
    localparam logic FUNC_MOVE = 1'b0;
    localparam logic FUNC_CHAR = 1'b1;

    // Configuration state handed to the rasterizer
    typedef struct packed {
        logic [15:0]      fg_color;
        logic [15:0]      bg_color;
        logic [3:0]       scale;
        logic [DIM_W-1:0] screen_width;
        logic [DIM_W-1:0] screen_height;
    } t_cfg;

    // One result request
    typedef struct packed {
        logic        draw;
        logic [7:0]  rect_x;
        logic [7:0]  rect_y;
        logic [3:0]  rect_w;
        logic [5:0]  rect_h;
        logic [15:0] fill_color;
        logic        last;
    } t_rect;

endpackage

>>> design/ttr_glyph_rom.sv
// 5x7 column font ROM with registered read and read enable.
`timescale 1ns / 1ps

module ttr_glyph_rom
    import ttr_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rd_en,
    input  logic [GLYPH_AW-1:0] i_addr,
    output logic [GLYPH_W-1:0]  o_data
);

    // One entry per code from space upward, column 0 in the top byte
    localparam logic [GLYPH_W-1:0] GLYPHS [0:GLYPH_CNT-1] = '{
        40'h0000000000, 40'h00005F0000, 40'h0007000700,
        40'h147F147F14, 40'h242A7F2A12, 40'h2313086462,
        40'h3649552250, 40'h0005030000, 40'h001C224100,
        40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
        40'h0050300000, 40'h0808080808, 40'h0060600000,
        40'h2010080402, 40'h3E5149453E, 40'h00427F4000,
        40'h4261514946, 40'h2141454B31, 40'h1814127F10,
        40'h2745454539, 40'h3C4A494930, 40'h0171090503,
        40'h3649494936, 40'h064949291E, 40'h0036360000,
        40'h0056360000, 40'h0814224100, 40'h1414141414,
        40'h0041221408, 40'h0201510906, 40'h324979413E,
        40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
        40'h7F4141221C, 40'h7F49494941, 40'h7F09090901,
        40'h3E4149497A, 40'h7F0808087F, 40'h00417F4100,
        40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
        40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
        40'h7F09090906, 40'h3E4151215E, 40'h7F09192946,
        40'h4649494931, 40'h01017F0101, 40'h3F4040403F,
        40'h1F2040201F, 40'h3F4038403F, 40'h6314081463,
        40'h0708700807, 40'h6151494543, 40'h007F414100,
        40'h0204081020, 40'h0041417F00, 40'h0402010204,
        40'h4040404040, 40'h0001020400, 40'h2054545478,
        40'h7F48444438, 40'h3844444420, 40'h384444487F,
        40'h3854545418, 40'h087E090102, 40'h0C5252523E,
        40'h7F08040478, 40'h00447D4000, 40'h2040443D00,
        40'h7F10284400, 40'h00417F4000, 40'h7C04180478,
        40'h7C08040478, 40'h3844444438, 40'h7C14141408,
        40'h081414187C, 40'h7C08040408, 40'h4854545420,
        40'h043F444020, 40'h3C4040207C, 40'h1C2040201C,
        40'h3C4030403C, 40'h4428102844, 40'h0C5050503C,
        40'h4464544C44
    };

    // Read port, data held until the next enabled read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_data <= GLYPHS[i_addr];
        end
    end

endmodule

>>> design/ttr_raster.sv
// Character sequencer: walks glyph cells, clips rectangles, keeps the cursor.
`timescale 1ns / 1ps

module ttr_raster
    import ttr_pkg::*;
#(
    parameter int MAX_SCALE = MAX_SCALE_DEF
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_func,
    input  logic [7:0]  i_char_code,
    input  logic [15:0] i_pos_x,
    input  logic [15:0] i_pos_y,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_rect       o_out
);

    localparam int SW = $clog2(MAX_SCALE + 1);
    localparam int MW = SW + 3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CELLS,
        ST_FLUSH
    } t_state;

    t_state            r_state;
    logic [CUR_W-1:0]  r_cur_col;
    logic [CUR_W-1:0]  r_cur_row;
    logic [SW-1:0]     r_s;
    logic [MW-1:0]     r_s6;
    logic [MW-1:0]     r_s7;
    logic [MW-1:0]     r_s8;
    logic [2:0]        r_col;
    logic [2:0]        r_row;
    logic [POS_W-1:0]  r_px;
    logic [POS_W-1:0]  r_py;
    logic              r_pend_valid;
    t_rect             r_pend;
    logic              r_out_valid;
    t_rect             r_out;

    logic [GLYPH_W-1:0]  glyph;
    logic [GLYPH_AW-1:0] rom_addr;
    logic                accept;
    logic [SW-1:0]       eff_s;
    logic [DIM_W-1:0]    sw_eff;
    logic [DIM_W-1:0]    sh_eff;
    logic                opaque;
    logic                out_free;
    logic [7:0]          col_byte;
    logic                cell_bit;
    logic                is_space;
    logic                cand_want;
    logic                cand_vis;
    logic                cand_emit;
    logic                stall;
    logic                load_out;
    logic [DIM_W-1:0]    rem_w;
    logic [DIM_W-1:0]    rem_h;
    logic [DIM_W-1:0]    full_w;
    logic [DIM_W-1:0]    full_h;
    logic [DIM_W-1:0]    clip_w;
    logic [DIM_W-1:0]    clip_h;
    t_rect               cand;
    t_rect               ack;
    t_rect               fin;
    logic [POS_W-1:0]    adv_sum;
    logic [CUR_W-1:0]    adv_col;
    logic [POS_W-1:0]    wrap_chk;
    logic                wrap;

    // Out-of-range codes map to the space glyph
    always_comb begin
        if (i_char_code < 8'(FIRST_CODE) || i_char_code > 8'(LAST_CODE)) begin
            rom_addr = '0;
        end else begin
            rom_addr = GLYPH_AW'(i_char_code - 8'(FIRST_CODE));
        end
    end

    assign o_ready = (r_state == ST_IDLE);
    assign accept  = i_valid && o_ready;

    ttr_glyph_rom u_rom (
        .i_clk   (i_clk),
        .i_rd_en (accept && (i_func == FUNC_CHAR)),
        .i_addr  (rom_addr),
        .o_data  (glyph)
    );

    // Effective scale and screen size
    always_comb begin
        if (i_cfg.scale == 4'd0) begin
            eff_s = SW'(1);
        end else if (int'(i_cfg.scale) > MAX_SCALE) begin
            eff_s = SW'(MAX_SCALE);
        end else begin
            eff_s = SW'(i_cfg.scale);
        end
    end

    assign sw_eff = (i_cfg.screen_width  > 9'd256) ? 9'd256 : i_cfg.screen_width;
    assign sh_eff = (i_cfg.screen_height > 9'd256) ? 9'd256 : i_cfg.screen_height;
    assign opaque = (i_cfg.bg_color != i_cfg.fg_color);

    assign out_free = !r_out_valid || i_out_ready;

    // Current cell: glyph bit, color choice and visibility
    assign col_byte = glyph[GLYPH_W-1 - 8*r_col -: 8];
    assign cell_bit = col_byte[r_row];
    assign is_space = (r_col == 3'(GLYPH_COLS));
    assign cand_want = is_space ? opaque : (cell_bit || opaque);
    assign cand_vis  = (r_px < POS_W'(sw_eff)) && (r_py < POS_W'(sh_eff));
    assign cand_emit = cand_want && cand_vis;
    assign stall     = cand_emit && r_pend_valid && !out_free;

    // Output register is loaded by a cell that pushes the pending result, or by flush
    assign load_out = ((r_state == ST_CELLS) && !stall && cand_emit && r_pend_valid) ||
                      ((r_state == ST_FLUSH) && out_free);

    // Clip to the right and bottom screen edges
    assign rem_w  = sw_eff - r_px[DIM_W-1:0];
    assign rem_h  = sh_eff - r_py[DIM_W-1:0];
    assign full_w = DIM_W'(r_s);
    assign full_h = is_space ? DIM_W'(r_s7) : DIM_W'(r_s);
    assign clip_w = (rem_w < full_w) ? rem_w : full_w;
    assign clip_h = (rem_h < full_h) ? rem_h : full_h;

    always_comb begin
        cand.draw       = 1'b1;
        cand.rect_x     = r_px[7:0];
        cand.rect_y     = r_py[7:0];
        cand.rect_w     = clip_w[3:0];
        cand.rect_h     = clip_h[5:0];
        cand.fill_color = (!is_space && cell_bit) ? i_cfg.fg_color : i_cfg.bg_color;
        cand.last       = 1'b0;
    end

    always_comb begin
        ack            = '0;
        ack.last       = 1'b1;
    end

    // Final rectangle of a character carries the last flag
    always_comb begin
        fin      = r_pend;
        fin.last = 1'b1;
    end

    // Cursor advance with line wrap
    assign adv_sum  = POS_W'(r_cur_col) + POS_W'(r_s6);
    assign adv_col  = adv_sum[CUR_W-1:0];
    assign wrap_chk = POS_W'(adv_col) + POS_W'(r_s6);
    assign wrap     = wrap_chk > POS_W'(sw_eff);

    // Sequencer, cursor, pending result and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_cur_col    <= '0;
            r_cur_row    <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        if (i_func == FUNC_MOVE) begin
                            r_cur_col <= i_pos_x;
                            r_cur_row <= i_pos_y;
                            r_state   <= ST_FLUSH;
                        end else begin
                            r_s     <= eff_s;
                            r_s6    <= MW'(eff_s) * MW'(ADVANCE);
                            r_s7    <= MW'(eff_s) * MW'(GLYPH_ROWS);
                            r_s8    <= MW'(eff_s) * MW'(LINE_STEP);
                            r_col   <= '0;
                            r_row   <= '0;
                            r_px    <= POS_W'(r_cur_col);
                            r_py    <= POS_W'(r_cur_row);
                            r_state <= ST_CELLS;
                        end
                    end
                end
                ST_CELLS: begin
                    if (!stall) begin
                        if (cand_emit) begin
                            if (r_pend_valid) begin
                                r_out <= r_pend;
                            end
                            r_pend       <= cand;
                            r_pend_valid <= 1'b1;
                        end
                        if (is_space) begin
                            if (wrap) begin
                                r_cur_col <= '0;
                                r_cur_row <= r_cur_row + CUR_W'(r_s8);
                            end else begin
                                r_cur_col <= adv_col;
                            end
                            r_state <= ST_FLUSH;
                        end else if (r_row == 3'(GLYPH_ROWS - 1)) begin
                            r_row <= '0;
                            r_col <= r_col + 3'd1;
                            r_px  <= r_px + POS_W'(r_s);
                            r_py  <= POS_W'(r_cur_row);
                        end else begin
                            r_row <= r_row + 3'd1;
                            r_py  <= r_py + POS_W'(r_s);
                        end
                    end
                end
                ST_FLUSH: begin
                    if (out_free) begin
                        r_out        <= r_pend_valid ? fin : ack;
                        r_pend_valid <= 1'b0;
                        r_state      <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef SYNTHESIS
    // No half-built result is left over when a new item is taken
    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_pend_valid)
        else $error("pending result left in idle");

    // Cell counters stay inside the glyph plus spacing column
    a_cell_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CELLS) |-> (r_col <= 3'(GLYPH_COLS)) && (r_row < 3'(GLYPH_ROWS)))
        else $error("cell counter out of range");

    // A cursor move goes straight to its acknowledge
    a_move_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_func == FUNC_MOVE)) |=> (r_state == ST_FLUSH))
        else $error("move did not reach flush");

    // Results leaving the cell walk are never marked last
    a_cells_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_state) == ST_CELLS && r_out_valid && !$past(r_out_valid && !i_out_ready))
        |-> !r_out.last)
        else $error("last flagged before flush");
`endif

endmodule

>>> design/text_to_rectangle_renderer.sv
// Top level: stream ports, configuration registers and the rasterizer.
`timescale 1ns / 1ps
// New requests are taken only in idle. A cursor move enters the flush state, which loads
// its acknowledge into the output register; a character's first rectangle waits in the
// pending register until the next one is found or the flush. Each character takes 36
// cell steps of the sequencer plus accept and flush, longer while the output side stalls.
// Reset (synchronous, active low): cursor to 0,0, registers to their defaults,
// output and pending results emptied. No memory clearing is needed.

module text_to_rectangle_renderer
    import ttr_pkg::*;
#(
    parameter int MAX_SCALE = MAX_SCALE_DEF
)
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Input stream
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [39:0]          i_s_tdata,   // char_code[7:0], pos_x[23:8], pos_y[39:24]
    input  logic                 i_s_tuser,   // func
    // Output stream
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [47:0]          o_m_tdata,   // rect_x[7:0], rect_y[15:8], rect_w[19:16],
                                              // rect_h[25:20], fill_color[41:26], zero fill
    output logic                 o_m_tuser,   // draw
    output logic                 o_m_tlast,
    // Configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]          i_cfg_data
);

    t_cfg  r_cfg;
    t_rect out_rect;

    // Configuration registers, always writable
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fg_color      <= 16'hFFFF;
            r_cfg.bg_color      <= 16'h0000;
            r_cfg.scale         <= 4'd1;
            r_cfg.screen_width  <= 9'd128;
            r_cfg.screen_height <= 9'd160;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FG_COLOR: r_cfg.fg_color      <= i_cfg_data;
                CFG_BG_COLOR: r_cfg.bg_color      <= i_cfg_data;
                CFG_SCALE:    r_cfg.scale         <= i_cfg_data[3:0];
                CFG_SCR_W:    r_cfg.screen_width  <= i_cfg_data[DIM_W-1:0];
                CFG_SCR_H:    r_cfg.screen_height <= i_cfg_data[DIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    ttr_raster #(
        .MAX_SCALE (MAX_SCALE)
    ) u_raster (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_func      (i_s_tuser),
        .i_char_code (i_s_tdata[7:0]),
        .i_pos_x     (i_s_tdata[23:8]),
        .i_pos_y     (i_s_tdata[39:24]),
        .o_out_valid (o_m_tvalid),
        .i_out_ready (i_m_tready),
        .o_out       (out_rect)
    );

    // Pack the result fields
    assign o_m_tdata = {6'd0, out_rect.fill_color, out_rect.rect_h, out_rect.rect_w,
                        out_rect.rect_y, out_rect.rect_x};
    assign o_m_tuser = out_rect.draw;
    assign o_m_tlast = out_rect.last;

endmodule

>>> tb/tb_text_to_rectangle_renderer.sv
// Self-checking testbench for the scaled 5x7 text rectangle renderer.
`timescale 1ns / 1ps

module tb_text_to_rectangle_renderer
    import ttr_pkg::*;
();

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int REPORT_MAX   = 10;

    // DUT ports
    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_s_tvalid  = 1'b0;
    logic        o_s_tready;
    logic [39:0] i_s_tdata   = '0;   // char_code[7:0], pos_x[23:8], pos_y[39:24]
    logic        i_s_tuser   = 1'b0; // func
    logic        o_m_tvalid;
    logic        i_m_tready  = 1'b0;
    logic [47:0] o_m_tdata;          // rect_x, rect_y, rect_w, rect_h, fill_color, zero fill
    logic        o_m_tuser;          // draw
    logic        o_m_tlast;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [15:0] i_cfg_data  = '0;

    // Predictor state: register shadow and text cursor
    t_cfg        cfg_shadow;
    logic [15:0] cursor_col;
    logic [15:0] cursor_row;

    // Rectangles still owed by the block, oldest first
    t_rect       expected_rects[$];
    t_rect       held_rect;
    logic        held_valid;

    // Run statistics and knobs
    int          cycle_count  = 0;
    int          rect_errors  = 0;
    int          rects_seen   = 0;
    int          moves_sent   = 0;
    int          chars_sent   = 0;
    int          send_idle    = 0;
    int          recv_stall   = 0;

    text_to_rectangle_renderer u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Clock, 12 ns period
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Receiver back-pressure
    always @(posedge i_clk) begin
        i_m_tready <= (recv_stall == 0) ? 1'b1 : ($urandom_range(0, 99) >= recv_stall);
    end

    // Font columns, col0 in the top byte; bit r of a column is row r
    function automatic logic [39:0] font_cols(input logic [7:0] code);
        case (code)
            8'h20: font_cols = 40'h0000000000;
            8'h21: font_cols = 40'h00005F0000;
            8'h22: font_cols = 40'h0007000700;
            8'h23: font_cols = 40'h147F147F14;
            8'h24: font_cols = 40'h242A7F2A12;
            8'h25: font_cols = 40'h2313086462;
            8'h26: font_cols = 40'h3649552250;
            8'h27: font_cols = 40'h0005030000;
            8'h28: font_cols = 40'h001C224100;
            8'h29: font_cols = 40'h0041221C00;
            8'h2A: font_cols = 40'h14083E0814;
            8'h2B: font_cols = 40'h08083E0808;
            8'h2C: font_cols = 40'h0050300000;
            8'h2D: font_cols = 40'h0808080808;
            8'h2E: font_cols = 40'h0060600000;
            8'h2F: font_cols = 40'h2010080402;
            8'h30: font_cols = 40'h3E5149453E;
            8'h31: font_cols = 40'h00427F4000;
            8'h32: font_cols = 40'h4261514946;
            8'h33: font_cols = 40'h2141454B31;
            8'h34: font_cols = 40'h1814127F10;
            8'h35: font_cols = 40'h2745454539;
            8'h36: font_cols = 40'h3C4A494930;
            8'h37: font_cols = 40'h0171090503;
            8'h38: font_cols = 40'h3649494936;
            8'h39: font_cols = 40'h064949291E;
            8'h3A: font_cols = 40'h0036360000;
            8'h3B: font_cols = 40'h0056360000;
            8'h3C: font_cols = 40'h0814224100;
            8'h3D: font_cols = 40'h1414141414;
            8'h3E: font_cols = 40'h0041221408;
            8'h3F: font_cols = 40'h0201510906;
            8'h40: font_cols = 40'h324979413E;
            8'h41: font_cols = 40'h7E1111117E;
            8'h42: font_cols = 40'h7F49494936;
            8'h43: font_cols = 40'h3E41414122;
            8'h44: font_cols = 40'h7F4141221C;
            8'h45: font_cols = 40'h7F49494941;
            8'h46: font_cols = 40'h7F09090901;
            8'h47: font_cols = 40'h3E4149497A;
            8'h48: font_cols = 40'h7F0808087F;
            8'h49: font_cols = 40'h00417F4100;
            8'h4A: font_cols = 40'h2040413F01;
            8'h4B: font_cols = 40'h7F08142241;
            8'h4C: font_cols = 40'h7F40404040;
            8'h4D: font_cols = 40'h7F020C027F;
            8'h4E: font_cols = 40'h7F0408107F;
            8'h4F: font_cols = 40'h3E4141413E;
            8'h50: font_cols = 40'h7F09090906;
            8'h51: font_cols = 40'h3E4151215E;
            8'h52: font_cols = 40'h7F09192946;
            8'h53: font_cols = 40'h4649494931;
            8'h54: font_cols = 40'h01017F0101;
            8'h55: font_cols = 40'h3F4040403F;
            8'h56: font_cols = 40'h1F2040201F;
            8'h57: font_cols = 40'h3F4038403F;
            8'h58: font_cols = 40'h6314081463;
            8'h59: font_cols = 40'h0708700807;
            8'h5A: font_cols = 40'h6151494543;
            8'h5B: font_cols = 40'h007F414100;
            8'h5C: font_cols = 40'h0204081020;
            8'h5D: font_cols = 40'h0041417F00;
            8'h5E: font_cols = 40'h0402010204;
            8'h5F: font_cols = 40'h4040404040;
            8'h60: font_cols = 40'h0001020400;
            8'h61: font_cols = 40'h2054545478;
            8'h62: font_cols = 40'h7F48444438;
            8'h63: font_cols = 40'h3844444420;
            8'h64: font_cols = 40'h384444487F;
            8'h65: font_cols = 40'h3854545418;
            8'h66: font_cols = 40'h087E090102;
            8'h67: font_cols = 40'h0C5252523E;
            8'h68: font_cols = 40'h7F08040478;
            8'h69: font_cols = 40'h00447D4000;
            8'h6A: font_cols = 40'h2040443D00;
            8'h6B: font_cols = 40'h7F10284400;
            8'h6C: font_cols = 40'h00417F4000;
            8'h6D: font_cols = 40'h7C04180478;
            8'h6E: font_cols = 40'h7C08040478;
            8'h6F: font_cols = 40'h3844444438;
            8'h70: font_cols = 40'h7C14141408;
            8'h71: font_cols = 40'h081414187C;
            8'h72: font_cols = 40'h7C08040408;
            8'h73: font_cols = 40'h4854545420;
            8'h74: font_cols = 40'h043F444020;
            8'h75: font_cols = 40'h3C4040207C;
            8'h76: font_cols = 40'h1C2040201C;
            8'h77: font_cols = 40'h3C4030403C;
            8'h78: font_cols = 40'h4428102844;
            8'h79: font_cols = 40'h0C5050503C;
            8'h7A: font_cols = 40'h4464544C44;
            default: font_cols = 40'h0000000000;
        endcase
    endfunction

    // Clip one rectangle to the screen; the previous one is queued as not last
    task automatic clip_rect(input int x, input int y, input int w, input int h,
                             input logic [15:0] color);
        int sw;
        int sh;
        t_rect rect;
        sw = (cfg_shadow.screen_width > 256) ? 256 : int'(cfg_shadow.screen_width);
        sh = (cfg_shadow.screen_height > 256) ? 256 : int'(cfg_shadow.screen_height);
        if (x >= sw || y >= sh) return;
        if (x + w > sw) w = sw - x;
        if (y + h > sh) h = sh - y;
        rect.draw       = 1'b1;
        rect.rect_x     = 8'(x);
        rect.rect_y     = 8'(y);
        rect.rect_w     = 4'(w);
        rect.rect_h     = 6'(h);
        rect.fill_color = color;
        rect.last       = 1'b0;
        if (held_valid) expected_rects.push_back(held_rect);
        held_rect  = rect;
        held_valid = 1'b1;
    endtask

    // Work out every rectangle one accepted request causes
    task automatic render_request(input logic func, input logic [7:0] code,
                                  input logic [15:0] pos_x, input logic [15:0] pos_y);
        int          s;
        int          sw;
        int          x0;
        int          y0;
        logic [39:0] glyph;
        logic [7:0]  col_bits;
        logic        opaque;
        held_valid = 1'b0;
        if (func == FUNC_MOVE) begin
            cursor_col = pos_x;
            cursor_row = pos_y;
        end else begin
            s = (cfg_shadow.scale == 0) ? 1 :
                (cfg_shadow.scale > MAX_SCALE_DEF) ? MAX_SCALE_DEF : int'(cfg_shadow.scale);
            sw = (cfg_shadow.screen_width > 256) ? 256 : int'(cfg_shadow.screen_width);
            x0 = int'(cursor_col);
            y0 = int'(cursor_row);
            opaque = (cfg_shadow.bg_color != cfg_shadow.fg_color);
            // Out-of-range codes fall to the blank glyph
            if (code < FIRST_CODE || code > LAST_CODE) code = FIRST_CODE;
            glyph = font_cols(code);
            for (int c = 0; c < GLYPH_COLS; c++) begin
                col_bits = glyph[39 - 8 * c -: 8];
                for (int r = 0; r < GLYPH_ROWS; r++) begin
                    if (col_bits[r])
                        clip_rect(x0 + c * s, y0 + r * s, s, s, cfg_shadow.fg_color);
                    else if (opaque)
                        clip_rect(x0 + c * s, y0 + r * s, s, s, cfg_shadow.bg_color);
                end
            end
            // Spacing column
            if (opaque)
                clip_rect(x0 + GLYPH_COLS * s, y0, s, GLYPH_ROWS * s, cfg_shadow.bg_color);
            // Advance and wrap
            cursor_col = 16'(int'(cursor_col) + ADVANCE * s);
            if (int'(cursor_col) + ADVANCE * s > sw) begin
                cursor_col = '0;
                cursor_row = 16'(int'(cursor_row) + LINE_STEP * s);
            end
        end
        // Nothing drawn: a bare acknowledge
        if (!held_valid) begin
            held_rect  = '0;
            held_valid = 1'b1;
        end
        held_rect.last = 1'b1;
        expected_rects.push_back(held_rect);
    endtask

    // Send one request, with a random hold-off before it in idle phases
    task automatic send_item(input logic func, input logic [7:0] code,
                             input logic [15:0] pos_x, input logic [15:0] pos_y);
        if (send_idle > 0 && $urandom_range(0, 99) < send_idle) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= func;
        i_s_tdata  <= {pos_y, pos_x, code};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        render_request(func, code, pos_x, pos_y);
        if (func == FUNC_MOVE) moves_sent++;
        else chars_sent++;
    endtask

    task automatic send_move(input int x, input int y);
        send_item(FUNC_MOVE, 8'($urandom), 16'(x), 16'(y));
    endtask

    task automatic send_char(input logic [7:0] code);
        send_item(FUNC_CHAR, code, 16'($urandom), 16'($urandom));
    endtask

    // Stop sending and wait until every owed rectangle has come back
    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_rects.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] index, input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (index)
            CFG_FG_COLOR: cfg_shadow.fg_color      = data;
            CFG_BG_COLOR: cfg_shadow.bg_color      = data;
            CFG_SCALE:    cfg_shadow.scale         = data[3:0];
            CFG_SCR_W:    cfg_shadow.screen_width  = data[DIM_W-1:0];
            CFG_SCR_H:    cfg_shadow.screen_height = data[DIM_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Drain, then write all five registers
    task automatic apply_config(input logic [15:0] fg, input logic [15:0] bg,
                                input logic [15:0] scale_d, input logic [15:0] width_d,
                                input logic [15:0] height_d);
        drain_results();
        cfg_write(CFG_FG_COLOR, fg);
        cfg_write(CFG_BG_COLOR, bg);
        cfg_write(CFG_SCALE, scale_d);
        cfg_write(CFG_SCR_W, width_d);
        cfg_write(CFG_SCR_H, height_d);
    endtask

    // Random settings, mostly small scales and sane screens, junk in unused bits
    task automatic random_config();
        logic [15:0] fg;
        logic [15:0] bg;
        logic [3:0]  scale_v;
        logic [8:0]  width_v;
        logic [8:0]  height_v;
        fg = 16'($urandom);
        bg = ($urandom_range(0, 3) == 0) ? fg : 16'($urandom);
        scale_v = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(1, 3)) : 4'($urandom);
        width_v = ($urandom_range(0, 9) < 8) ? 9'($urandom_range(16, 256)) : 9'($urandom);
        height_v = ($urandom_range(0, 9) < 8) ? 9'($urandom_range(16, 256)) : 9'($urandom);
        apply_config(fg, bg, (16'($urandom) & 16'hFFF0) | 16'(scale_v),
                     (16'($urandom) & 16'hFE00) | 16'(width_v),
                     (16'($urandom) & 16'hFE00) | 16'(height_v));
    endtask

    // Reset settings: glyph ROM ends, out-of-range codes, corner clip
    task automatic test_reset_defaults();
        send_move(0, 0);
        send_char(8'h41);
        send_char(8'h00);
        send_char(8'hFF);
        send_char(8'h1F);
        send_char(8'h7B);
        send_char(8'h7A);
        send_char(8'h20);
        send_move(125, 155);
        send_char(8'h23);
    endtask

    // Largest scale, full screen, clipping at the edge, off-screen and cursor wrap
    task automatic test_scale_and_clip_extremes();
        apply_config(16'h0000, 16'hFFFF, 16'd8, 16'd256, 16'd256);
        send_move(0, 0);
        send_char(8'h57);
        send_move(250, 250);
        send_char(8'h4D);
        send_move(65535, 65535);
        send_char(8'h25);
        send_char(8'h26);
    endtask

    // Zero height, saturated sizes and scales, transparent background, width one
    task automatic test_degenerate_screens();
        apply_config(16'hFFFF, 16'h0000, 16'hFFF0, 16'hFFFF, 16'h0000);
        send_move(5, 5);
        send_char(8'h42);
        apply_config(16'h5A5A, 16'h5A5A, 16'h000F, 16'h012C, 16'h0001);
        send_move(10, 0);
        send_char(8'h40);
        apply_config(16'hA5A5, 16'h1234, 16'd2, 16'd1, 16'd160);
        send_char(8'h69);
        send_char(8'h6A);
    endtask

    // Random text runs with cursor moves; settings change halfway after a full drain
    task automatic test_random_stream(input int n_items, input int idle_pct,
                                      input int stall_pct);
        int pick;
        drain_results();
        send_idle  = idle_pct;
        recv_stall = stall_pct;
        random_config();
        for (int i = 0; i < n_items; i++) begin
            if (i == n_items / 2) random_config();
            pick = $urandom_range(0, 99);
            if (pick < 15)
                send_move($urandom_range(0, 255), $urandom_range(0, 255));
            else if (pick < 20)
                send_move($urandom, $urandom);
            else if (pick < 85)
                send_char(8'($urandom_range(FIRST_CODE, LAST_CODE)));
            else
                send_char(8'($urandom));
        end
    endtask

    // Compare each returned rectangle with the oldest one owed
    always @(posedge i_clk) begin : check_rects
        t_rect got;
        t_rect want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.draw       = o_m_tuser;
            got.rect_x     = o_m_tdata[7:0];
            got.rect_y     = o_m_tdata[15:8];
            got.rect_w     = o_m_tdata[19:16];
            got.rect_h     = o_m_tdata[25:20];
            got.fill_color = o_m_tdata[41:26];
            got.last       = o_m_tlast;
            rects_seen++;
            if (expected_rects.size() == 0) begin
                if (rect_errors < REPORT_MAX)
                    $display("unexpected rect: draw=%0d x=%0d y=%0d w=%0d h=%0d c=%h last=%0d",
                             got.draw, got.rect_x, got.rect_y, got.rect_w, got.rect_h,
                             got.fill_color, got.last);
                rect_errors++;
            end else begin
                want = expected_rects.pop_front();
                if (got.draw !== want.draw || got.rect_x !== want.rect_x ||
                    got.rect_y !== want.rect_y || got.rect_w !== want.rect_w ||
                    got.rect_h !== want.rect_h || got.fill_color !== want.fill_color ||
                    got.last !== want.last) begin
                    if (rect_errors < REPORT_MAX) begin
                        $display("rect mismatch: exp draw=%0d x=%0d y=%0d w=%0d h=%0d c=%h last=%0d",
                                 want.draw, want.rect_x, want.rect_y, want.rect_w,
                                 want.rect_h, want.fill_color, want.last);
                        $display("               got draw=%0d x=%0d y=%0d w=%0d h=%0d c=%h last=%0d",
                                 got.draw, got.rect_x, got.rect_y, got.rect_w,
                                 got.rect_h, got.fill_color, got.last);
                    end
                    rect_errors++;
                end
            end
        end
    end

    // Watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("tb_text_to_rectangle_renderer: errors");
        $finish;
    end

    // Main sequence
    initial begin
        cfg_shadow.fg_color      = 16'hFFFF;
        cfg_shadow.bg_color      = 16'h0000;
        cfg_shadow.scale         = 4'd1;
        cfg_shadow.screen_width  = 9'd128;
        cfg_shadow.screen_height = 9'd160;
        cursor_col = '0;
        cursor_row = '0;
        held_valid = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_scale_and_clip_extremes();
        test_degenerate_screens();
        test_random_stream(59, 0, 0);
        test_random_stream(59, 72, 0);
        test_random_stream(59, 0, 72);
        test_random_stream(59, 32, 32);
        drain_results();

        $display("covered %0d cursor moves and %0d characters, %0d rectangle requests checked",
                 moves_sent, chars_sent, rects_seen);
        $display("settings spanned scales 0..15, screens from zero to 511, opaque and clear bg");
        if (rect_errors == 0) begin
            $display("tb_text_to_rectangle_renderer: clean");
        end else begin
            $display("tb_text_to_rectangle_renderer: errors");
        end
        $finish;
    end

endmodule

>>> files.f
design/ttr_pkg.sv
design/ttr_glyph_rom.sv
design/ttr_raster.sv
design/text_to_rectangle_renderer.sv
tb/tb_text_to_rectangle_renderer.sv
